// File: sv/fully_assoc_lru_tag_store_defines.svh
// Assertion macros for the fully associative LRU tag store.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef FULLY_ASSOC_LRU_TAG_STORE_DEFINES_SVH
`define FULLY_ASSOC_LRU_TAG_STORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FALTS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FALTS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: sv/falts_pkg.sv
// Shared constants and types for the fully associative LRU tag store.
// No dependencies.
`default_nettype none

package falts_pkg;

  localparam int LINES    = 16;
  localparam int OFFSET_W = 4;
  localparam int ADDR_W   = 32;
  localparam int TAG_W    = ADDR_W - OFFSET_W;
  localparam int LINE_W   = $clog2(LINES);
  localparam int CNT_W    = 32;
  localparam int OUT_W    = 72;

  typedef logic [TAG_W-1:0]             tag_t;
  typedef logic [LINE_W-1:0]            line_idx_t;
  typedef logic [LINES-1:0][TAG_W-1:0]  tag_arr_t;
  typedef logic [LINES-1:0][LINE_W-1:0] age_arr_t;

  typedef struct packed {
    logic      hit;
    line_idx_t line;
  } lookup_t;

endpackage

`default_nettype wire

// File: sv/falts_lookup.sv
// Parallel tag compare, fill/victim choice and age-rank update.
// Purely combinational; depends on falts_pkg.
`default_nettype none

module falts_lookup (
  input  falts_pkg::tag_t              tag,
  input  logic [falts_pkg::LINES-1:0]  valid,
  input  falts_pkg::tag_arr_t          tags,
  input  falts_pkg::age_arr_t          ages,
  output falts_pkg::lookup_t           res,
  output falts_pkg::age_arr_t          ages_nxt
);
  import falts_pkg::*;

  localparam line_idx_t AGE_MAX = line_idx_t'(LINES - 1);

  logic [LINES-1:0] hit_vec;
  line_idx_t        hit_idx;
  line_idx_t        empty_idx;
  line_idx_t        victim_idx;
  line_idx_t        ref_age;
  logic             full;

  always_comb begin
    hit_idx    = '0;
    empty_idx  = '0;
    victim_idx = '0;
    for (int i = 0; i < LINES; i++) begin
      hit_vec[i] = valid[i] && (tags[i] == tag);
    end
    // descending scan: lowest index wins
    for (int i = LINES - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = line_idx_t'(i);
      if (!valid[i]) empty_idx = line_idx_t'(i);
      // with all lines valid the ranks are distinct, so the oldest holds the top rank
      if (ages[i] == AGE_MAX) victim_idx = line_idx_t'(i);
    end
  end

  assign full     = &valid;
  assign ref_age  = ages[hit_idx];
  assign res.hit  = |hit_vec;
  assign res.line = res.hit ? hit_idx : (full ? victim_idx : empty_idx);

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      if (line_idx_t'(i) == res.line) begin
        ages_nxt[i] = '0;
      end else if (valid[i] && (!res.hit || (ages[i] < ref_age))) begin
        ages_nxt[i] = ages[i] + 1'b1;
      end else begin
        ages_nxt[i] = ages[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/fully_assoc_lru_tag_store.sv
// Top level of the 16-line fully associative tag store with LRU replacement.
// Depends on falts_pkg, falts_lookup and fully_assoc_lru_tag_store_defines.svh.
//
//   channel | direction | tdata bits | contents
//   in_     | slave     | 32         | address
//   out_    | master    | 72         | hit, line_used, hit_total, access_total
//
// One beat per cycle unless out_ stalls; out_tvalid is the result register's valid bit.
// Input register feeds the tag compare and age update; result register drives out_.
// The line state updates as a beat moves from input to result register, so
// consecutive beats see each other's effect with no bubble.
// Synchronous active-low reset clears valid bits, counters and handshake state.
// An out_ stall holds the result and backs up to in_tready after one beat.
`default_nettype none

module fully_assoc_lru_tag_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [falts_pkg::ADDR_W-1:0]  in_tdata,   // [31:0] address
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [falts_pkg::OUT_W-1:0]   out_tdata   // [0] hit, [4:1] line_used,
                                                    // [36:5] hit_total,
                                                    // [68:37] access_total, [71:69] zero
);
  import falts_pkg::*;
  `include "fully_assoc_lru_tag_store_defines.svh"

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic                in_valid_r;
  logic [ADDR_W-1:0]   in_addr_r;
  logic [LINES-1:0]    line_valid_r;
  tag_arr_t            line_tag_r;
  age_arr_t            line_age_r;
  logic [CNT_W-1:0]    hit_cnt_r,  hit_cnt_nxt;
  logic [CNT_W-1:0]    acc_cnt_r,  acc_cnt_nxt;
  logic                out_valid_r;
  logic                out_hit_r;
  line_idx_t           out_line_r;

  tag_t                tag;
  lookup_t             lk;
  age_arr_t            ages_nxt;
  logic                advance;

  assign tag       = in_addr_r[ADDR_W-1:OFFSET_W];
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  falts_lookup u_lookup (
    .tag      (tag),
    .valid    (line_valid_r),
    .tags     (line_tag_r),
    .ages     (line_age_r),
    .res      (lk),
    .ages_nxt (ages_nxt)
  );

  assign acc_cnt_nxt = (acc_cnt_r == CNT_MAX) ? acc_cnt_r : acc_cnt_r + 1'b1;
  assign hit_cnt_nxt = (lk.hit && hit_cnt_r != CNT_MAX) ? hit_cnt_r + 1'b1 : hit_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      line_valid_r <= '0;
      hit_cnt_r    <= '0;
      acc_cnt_r    <= '0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) begin
        out_valid_r           <= 1'b1;
        line_valid_r[lk.line] <= 1'b1;
        hit_cnt_r             <= hit_cnt_nxt;
        acc_cnt_r             <= acc_cnt_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_addr_r <= in_tdata;
    if (advance) begin
      line_age_r          <= ages_nxt;
      line_tag_r[lk.line] <= tag;
      out_hit_r           <= lk.hit;
      out_line_r          <= lk.line;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, acc_cnt_r, hit_cnt_r, out_line_r, out_hit_r};

  `FALTS_ASSERT_NOW(a_hits_le_accesses, out_valid_r, hit_cnt_r <= acc_cnt_r, "hit count above access count")
  `FALTS_ASSERT_NEXT(a_line_filled, advance, line_valid_r[$past(lk.line)], "used line not valid after access")
  `FALTS_ASSERT_NEXT(a_acc_count, advance && acc_cnt_r != CNT_MAX, acc_cnt_r == $past(acc_cnt_r) + 1'b1, "access count did not advance")
  `FALTS_ASSERT_NEXT(a_used_newest, advance, line_age_r[$past(lk.line)] == '0, "used line not most recent")

endmodule

`default_nettype wire

// File: tb/sv/fully_assoc_lru_tag_store_test.sv
`timescale 1ns / 100ps
// Self-checking bench for fully_assoc_lru_tag_store: directed address table, then
// random address streams; each result beat checked against a typed row or the LRU model.
// Depends on falts_pkg and the RTL top level.
module fully_assoc_lru_tag_store_test;
  import falts_pkg::*;

  localparam int RANDOM_BEATS = 1600;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_AT      = 700;   // beat count that triggers the long out_ stall
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_BURST   = 48;    // back-to-back beats offered during the stall
  localparam int POOL_MAX     = 32;
  localparam int NUM_DIRECTED = 25;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  count_t;

  localparam count_t CNT_MAX = '1;

  typedef struct packed {
    logic      hit;
    line_idx_t line;
    count_t    hits;
    count_t    accesses;
  } lookup_result_t;

  typedef struct packed {
    addr_t          addr;
    logic           typed;   // use want as is, else take the model's answer
    lookup_result_t want;
  } address_row_t;

  // Two hits right after reset, 14 fills up to a full store, then replacements
  // and refreshes mixed with alternating-bit addresses.
  localparam address_row_t DIRECTED [NUM_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, '{1'b0, 4'd0, 32'd0, 32'd1}},
    '{32'h0000_000F, 1'b1, '{1'b1, 4'd0, 32'd1, 32'd2}},
    '{32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd1, 32'd1, 32'd3}},
    '{32'hFFFF_FFF0, 1'b1, '{1'b1, 4'd1, 32'd2, 32'd4}},
    '{32'h8000_0000, 1'b0, '0},
    '{32'h4000_0000, 1'b0, '0},
    '{32'h2000_0000, 1'b0, '0},
    '{32'h1000_0000, 1'b0, '0},
    '{32'h0800_0000, 1'b0, '0},
    '{32'h0400_0000, 1'b0, '0},
    '{32'h0200_0000, 1'b0, '0},
    '{32'h0100_0000, 1'b0, '0},
    '{32'h0080_0000, 1'b0, '0},
    '{32'h0040_0000, 1'b0, '0},
    '{32'h0020_0000, 1'b0, '0},
    '{32'h0010_0000, 1'b0, '0},
    '{32'h0008_0000, 1'b0, '0},
    '{32'h0004_0000, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h0000_0000, 1'b0, '0},
    '{32'h0004_0000, 1'b0, '0},
    '{32'h5555_555A, 1'b0, '0},
    '{32'h8000_0008, 1'b0, '0}
  };

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  addr_t             in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  logic              rx_hold    = 1'b0;
  int unsigned       beats_sent = 0;
  int unsigned       errors     = 0;
  int unsigned       cycles     = 0;

  lookup_result_t    expected_lookups [$];

  // LRU model state
  logic              lru_valid [LINES];
  tag_t              lru_tag   [LINES];
  line_idx_t         lru_age   [LINES];
  count_t            lru_hits;
  count_t            lru_accesses;

  tag_t              tag_pool  [POOL_MAX];

  always #10 clk = ~clk;

  fully_assoc_lru_tag_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void lru_clear();
    int i;
    for (i = 0; i < LINES; i++) begin
      lru_valid[i] = 1'b0;
      lru_tag[i]   = '0;
      lru_age[i]   = '0;
    end
    lru_hits     = '0;
    lru_accesses = '0;
  endfunction

  // Look the address up, update recency and counters, return the result beat.
  function automatic lookup_result_t lru_lookup(input addr_t addr);
    tag_t           t;
    int             i;
    int             slot;
    line_idx_t      oldest;
    line_idx_t      limit;
    lookup_result_t r;
    t    = addr[ADDR_W-1:OFFSET_W];
    slot = -1;
    if (lru_accesses != CNT_MAX) lru_accesses++;
    for (i = 0; i < LINES; i++) begin
      if (slot < 0 && lru_valid[i] && lru_tag[i] == t) slot = i;
    end
    r.hit = (slot >= 0);
    if (r.hit) begin
      if (lru_hits != CNT_MAX) lru_hits++;
      limit = lru_age[slot];
      for (i = 0; i < LINES; i++) begin
        if (i != slot && lru_valid[i] && lru_age[i] < limit) lru_age[i]++;
      end
    end else begin
      for (i = 0; i < LINES; i++) begin
        if (slot < 0 && !lru_valid[i]) slot = i;
      end
      if (slot < 0) begin
        // full: oldest line goes, lowest index on a tie
        slot   = 0;
        oldest = '0;
        for (i = 0; i < LINES; i++) begin
          if (lru_age[i] > oldest) begin
            oldest = lru_age[i];
            slot   = i;
          end
        end
      end
      lru_valid[slot] = 1'b1;
      lru_tag[slot]   = t;
      for (i = 0; i < LINES; i++) begin
        if (i != slot && lru_valid[i]) lru_age[i]++;
      end
    end
    lru_age[slot] = '0;
    r.line     = line_idx_t'(slot);
    r.hits     = lru_hits;
    r.accesses = lru_accesses;
    return r;
  endfunction

  // Mostly no gap, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_address(input addr_t addr, input int unsigned gap,
                              input logic typed, input lookup_result_t want);
    lookup_result_t model_out;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    model_out = lru_lookup(addr);
    expected_lookups.push_back(typed ? want : model_out);
    beats_sent++;
  endtask

  task automatic check_result(input logic [OUT_W-1:0] beat);
    lookup_result_t got;
    lookup_result_t want;
    got.hit      = beat[0];
    got.line     = beat[4:1];
    got.hits     = beat[36:5];
    got.accesses = beat[68:37];
    if (expected_lookups.size() == 0) begin
      $error("result beat with nothing expected: %h", beat);
      errors++;
      return;
    end
    want = expected_lookups.pop_front();
    if (got.hit !== want.hit) begin
      $error("hit: expected %0d, got %0d", want.hit, got.hit);
      errors++;
    end
    if (got.line !== want.line) begin
      $error("line_used: expected %0d, got %0d", want.line, got.line);
      errors++;
    end
    if (got.hits !== want.hits) begin
      $error("hit_total: expected %0d, got %0d", want.hits, got.hits);
      errors++;
    end
    if (got.accesses !== want.accesses) begin
      $error("access_total: expected %0d, got %0d", want.accesses, got.accesses);
      errors++;
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left   = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (stall_left > 0) stall_left--;
      else if (run_left > 0) run_left--;
      else begin
        stall_left = pick_gap();
        run_left   = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 12);
      end
      out_tready <= !rx_hold && stall_left == 0;
    end
  end

  // Long out_ stall while the sender keeps pushing, so the pipe backs up.
  initial begin : long_hold
    wait (beats_sent >= HOLD_AT);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : stimulus
    int unsigned    n;
    int unsigned    k;
    int unsigned    pool_size;
    int unsigned    scan_idx;
    int unsigned    gap;
    logic           scan;
    logic           steady;
    logic [31:0]    rnd;
    addr_t          addr;
    pool_size = 16;
    scan_idx  = 0;
    scan      = 1'b0;
    steady    = 1'b0;
    lru_clear();
    for (k = 0; k < POOL_MAX; k++) begin
      rnd         = $urandom;
      tag_pool[k] = rnd[TAG_W-1:0];
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < NUM_DIRECTED; n++)
      send_address(DIRECTED[n].addr, pick_gap(), DIRECTED[n].typed, DIRECTED[n].want);

    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) begin
        // working set sizes around the line count: fits, exact, one over, thrash
        case ($urandom_range(0, 6))
          0:       pool_size = 3;
          1:       pool_size = 8;
          2:       pool_size = 15;
          3:       pool_size = 16;
          4:       pool_size = 17;
          5:       pool_size = 20;
          default: pool_size = POOL_MAX;
        endcase
        scan   = ($urandom_range(0, 2) == 0);
        steady = ($urandom_range(0, 3) == 0);
        for (k = 0; k < POOL_MAX; k++) begin
          if ($urandom_range(0, 1) == 1) begin
            rnd         = $urandom;
            tag_pool[k] = rnd[TAG_W-1:0];
          end
        end
      end
      rnd = $urandom;
      if ($urandom_range(0, 4) == 0) addr = rnd;
      else begin
        if (scan) begin
          k = scan_idx % pool_size;
          scan_idx++;
        end else k = $urandom_range(0, pool_size - 1);
        addr = {tag_pool[k], rnd[OFFSET_W-1:0]};
      end
      if (steady || (beats_sent >= HOLD_AT && beats_sent < HOLD_AT + HOLD_BURST)) gap = 0;
      else gap = pick_gap();
      send_address(addr, gap, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
